>>> sv/bms_pkg.sv
// Shared types and constants of the buzzer melody sequencer.
package bms_pkg;

	localparam int TempoW = 16;
	localparam int FreqW  = 16;
	localparam int DutyW  = 8;
	localparam int LoudW  = 7;
	localparam int LenW   = 24;
	localparam int ElapW  = 16;
	localparam int SlotW  = 6;
	localparam int PtrW   = 7;
	localparam int TimeW  = 32;
	localparam int DivW   = 31;
	localparam int RemW   = 16;
	localparam int GapW   = 21;
	localparam int EntryW = FreqW + LoudW + LenW;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	localparam logic [TempoW-1:0] TempoDefault = 16'd120;
	localparam logic [7:0]        LeadUs       = 8'd125;
	// The note gap of 15000 us at 120 bpm, already multiplied by 120.
	localparam logic [DivW-1:0]   GapScaled    = 31'd1800000;
	// Reciprocal of 100 as 5243 / 2^19, exact for every loudness product.
	localparam logic [12:0]       Recip100     = 13'd5243;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_START = 2'd1,
		REQ_POLL  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [CfgIdxW-1:0] CFG_TEMPO    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MIN_FREQ = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_FREQ = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MIN_DUTY = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_MAX_DUTY = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_REPEAT   = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_LENGTH   = 3'd6;

	typedef struct packed {
		logic accept;
		logic decode;
		logic fetch;
		logic start_chk;
		logic div_go;
		logic div_gap;
		logic cap_len;
		logic cap_gap;
		logic stop_chk;
		logic finish;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic playing;
		logic can_fetch;
		logic will_sound;
		logic div_done;
	} stat_t;

endpackage

>>> sv/bms_div.sv
// Restoring divider producing one quotient bit per cycle.
module bms_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [bms_pkg::DivW-1:0]  dividend,
	input  logic [bms_pkg::RemW-1:0]  divisor,
	output logic [bms_pkg::DivW-1:0]  quotient,
	output logic                      done
);
	import bms_pkg::*;

	logic [DivW-1:0] quo_q;
	logic [RemW-1:0] rem_q;
	logic [RemW-1:0] dvs_q;
	logic [4:0]      cnt_q;
	logic            run_q;
	logic            done_q;
	logic [RemW:0]   trial;
	logic [RemW:0]   diff;
	logic            ge;

	assign trial = {rem_q, quo_q[DivW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= 5'(DivW);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
			quo_q <= {quo_q[DivW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> sv/bms_ctrl.sv
// Controller state machine sequencing each item through the datapath.
module bms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  bms_pkg::stat_t stat,
	output bms_pkg::cmd_t  cmd
);
	import bms_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_DECODE   = 11'b00000000010,
		S_FETCH    = 11'b00000000100,
		S_START    = 11'b00000001000,
		S_LEN_GO   = 11'b00000010000,
		S_LEN_WAIT = 11'b00000100000,
		S_GAP_GO   = 11'b00001000000,
		S_GAP_WAIT = 11'b00010000000,
		S_STOP     = 11'b00100000000,
		S_FINISH   = 11'b01000000000,
		S_DONE     = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.req == REQ_POLL && stat.playing) begin
					state_d = S_FETCH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FETCH: begin
				cmd.fetch = stat.can_fetch;
				state_d   = stat.can_fetch ? S_START : S_FINISH;
			end
			S_START: begin
				cmd.start_chk = 1'b1;
				state_d       = stat.will_sound ? S_LEN_GO : S_FINISH;
			end
			S_LEN_GO: begin
				cmd.div_go = 1'b1;
				state_d    = S_LEN_WAIT;
			end
			S_LEN_WAIT: begin
				cmd.cap_len = 1'b1;
				if (stat.div_done) begin
					state_d = S_GAP_GO;
				end
			end
			S_GAP_GO: begin
				cmd.div_go  = 1'b1;
				cmd.div_gap = 1'b1;
				state_d     = S_GAP_WAIT;
			end
			S_GAP_WAIT: begin
				cmd.cap_gap = 1'b1;
				if (stat.div_done) begin
					state_d = S_STOP;
				end
			end
			S_STOP: begin
				cmd.stop_chk = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

>>> sv/bms_dp.sv
// Datapath: configuration, note table, song state, timing and duty arithmetic.
module bms_dp #(
	parameter int MAX_NOTES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [bms_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bms_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [1:0]                    req_type,
	input  logic [bms_pkg::SlotW-1:0]     note_slot,
	input  logic [bms_pkg::FreqW-1:0]     note_freq_hz,
	input  logic [bms_pkg::LoudW-1:0]     note_loudness,
	input  logic [bms_pkg::LenW-1:0]      note_length_us,
	input  logic [bms_pkg::ElapW-1:0]     elapsed_us,
	input  bms_pkg::cmd_t                 cmd,
	output bms_pkg::stat_t                stat,
	output logic                          drive_update,
	output logic [bms_pkg::FreqW-1:0]     drive_freq_hz,
	output logic [bms_pkg::DutyW-1:0]     drive_duty,
	output logic                          song_active,
	output logic                          song_finished
);
	import bms_pkg::*;

	localparam int AddrW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int LenCap = (MAX_NOTES > 127) ? 127 : MAX_NOTES;

	// Configuration registers.
	logic [TempoW-1:0] tempo_q;
	logic [FreqW-1:0]  min_freq_q;
	logic [FreqW-1:0]  max_freq_q;
	logic [DutyW-1:0]  min_duty_q;
	logic [DutyW-1:0]  max_duty_q;
	logic              repeat_q;
	logic [PtrW-1:0]   length_q;

	// Item captured at acceptance.
	req_t             req_q;
	logic [SlotW-1:0] slot_q;
	logic [FreqW-1:0] freq_in_q;
	logic [LoudW-1:0] loud_in_q;
	logic [LenW-1:0]  len_in_q;
	logic [ElapW-1:0] elapsed_q;

	// Song state.
	logic [PtrW-1:0]  ptr_q;
	logic [TimeW-1:0] clock_q;
	logic [TimeW-1:0] start_us_q;
	logic             sounding_q;
	logic             end_q;
	logic             playing_q;

	logic [EntryW-1:0] note_table [MAX_NOTES];
	logic [EntryW-1:0] rd_q;
	logic [DivW-1:0]   scaled_q;
	logic [GapW-1:0]   gap_q;

	logic             upd_q;
	logic [FreqW-1:0] freq_q;
	logic [DutyW-1:0] duty_q;

	logic [PtrW-1:0]   len_eff;
	logic              ptr_lt_len;
	logic              slot_ok;
	logic [FreqW-1:0]  rd_freq;
	logic [LoudW-1:0]  rd_loud;
	logic [LenW-1:0]   rd_len;
	logic              start_hit;
	logic              in_window;
	logic [14:0]       loud255;
	logic [14:0]       max_h;
	logic [14:0]       min_h;
	logic [27:0]       recip_prod;
	logic [DutyW-1:0]  duty_val;
	logic [TimeW+1:0]  stop_lhs;
	logic [TimeW+1:0]  stop_rhs;
	logic              stop_hit;
	logic [TempoW-1:0] tempo_eff;
	logic [DivW-1:0]   len_x120;
	logic [DivW-1:0]   dividend;
	logic [DivW-1:0]   quotient;
	logic              div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q    <= TempoDefault;
			min_freq_q <= '0;
			max_freq_q <= '1;
			min_duty_q <= '0;
			max_duty_q <= '1;
			repeat_q   <= 1'b0;
			length_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TEMPO:    tempo_q    <= cfg_data;
				CFG_MIN_FREQ: min_freq_q <= cfg_data;
				CFG_MAX_FREQ: max_freq_q <= cfg_data;
				CFG_MIN_DUTY: min_duty_q <= cfg_data[DutyW-1:0];
				CFG_MAX_DUTY: max_duty_q <= cfg_data[DutyW-1:0];
				CFG_REPEAT:   repeat_q   <= cfg_data[0];
				CFG_LENGTH:   length_q   <= cfg_data[PtrW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= req_t'(req_type);
			slot_q    <= note_slot;
			freq_in_q <= note_freq_hz;
			loud_in_q <= note_loudness;
			len_in_q  <= note_length_us;
			elapsed_q <= elapsed_us;
		end
	end

	assign len_eff    = (length_q > PtrW'(LenCap)) ? PtrW'(LenCap) : length_q;
	assign ptr_lt_len = ptr_q < len_eff;
	assign slot_ok    = int'(slot_q) < MAX_NOTES;

	always_ff @(posedge clk) begin
		if (cmd.decode && req_q == REQ_WRITE && slot_ok) begin
			note_table[AddrW'(slot_q)] <= {freq_in_q, loud_in_q, len_in_q};
		end
		if (cmd.fetch) begin
			rd_q <= note_table[AddrW'(ptr_q)];
		end
	end

	assign rd_freq = rd_q[EntryW-1 -: FreqW];
	assign rd_loud = rd_q[LenW +: LoudW];
	assign rd_len  = rd_q[LenW-1:0];

	assign start_hit = !sounding_q &&
		(({1'b0, clock_q} + {25'd0, LeadUs}) >= {1'b0, start_us_q});
	assign in_window = (rd_freq >= min_freq_q) && (rd_freq <= max_freq_q);

	assign loud255    = ({8'd0, rd_loud} << 8) - {8'd0, rd_loud};
	assign max_h      = ({7'd0, max_duty_q} << 6) + ({7'd0, max_duty_q} << 5) +
		({7'd0, max_duty_q} << 2);
	assign min_h      = ({7'd0, min_duty_q} << 6) + ({7'd0, min_duty_q} << 5) +
		({7'd0, min_duty_q} << 2);
	assign recip_prod = {13'd0, loud255} * {15'd0, Recip100};

	always_comb begin
		if (loud255 >= max_h) begin
			duty_val = max_duty_q;
		end else if (loud255 <= min_h) begin
			duty_val = min_duty_q;
		end else begin
			duty_val = recip_prod[26:19];
		end
	end

	assign tempo_eff = (tempo_q == '0) ? TempoDefault : tempo_q;
	assign len_x120  = ({7'd0, rd_len} << 7) - ({7'd0, rd_len} << 3);
	assign dividend  = cmd.div_gap ? GapScaled : len_x120;

	bms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dividend),
		.divisor  (tempo_eff),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_len && div_done) begin
			scaled_q <= quotient;
		end
		if (cmd.cap_gap && div_done) begin
			gap_q <= quotient[GapW-1:0];
		end
	end

	// The stop test is clock >= start + scaled - gap, rearranged to stay unsigned.
	assign stop_lhs = {2'b0, clock_q} + {13'd0, gap_q};
	assign stop_rhs = {2'b0, start_us_q} + {3'd0, scaled_q};
	assign stop_hit = stop_lhs >= stop_rhs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			clock_q    <= '0;
			start_us_q <= '0;
			sounding_q <= 1'b0;
			end_q      <= 1'b0;
			playing_q  <= 1'b0;
			upd_q      <= 1'b0;
			freq_q     <= '0;
			duty_q     <= '0;
		end else begin
			if (cmd.decode) begin
				upd_q  <= (req_q == REQ_START) && sounding_q;
				freq_q <= '0;
				duty_q <= '0;
				if (req_q == REQ_START) begin
					ptr_q      <= '0;
					clock_q    <= '0;
					start_us_q <= '0;
					sounding_q <= 1'b0;
					end_q      <= 1'b0;
					playing_q  <= 1'b1;
				end else if (req_q == REQ_POLL && playing_q) begin
					if (end_q && repeat_q) begin
						ptr_q      <= '0;
						clock_q    <= '0;
						start_us_q <= '0;
						end_q      <= 1'b0;
					end else begin
						clock_q <= clock_q + {16'd0, elapsed_q};
						if (end_q) begin
							playing_q <= 1'b0;
						end
					end
				end
			end
			if (cmd.start_chk && start_hit) begin
				upd_q      <= 1'b1;
				sounding_q <= 1'b1;
				if (in_window) begin
					freq_q <= rd_freq;
					duty_q <= duty_val;
				end
			end
			if (cmd.stop_chk && stop_hit) begin
				upd_q      <= 1'b1;
				duty_q     <= '0;
				sounding_q <= 1'b0;
				start_us_q <= start_us_q + {1'b0, scaled_q};
				ptr_q      <= ptr_q + 7'd1;
			end
			if (cmd.finish && playing_q && !ptr_lt_len) begin
				end_q <= 1'b1;
			end
		end
	end

	assign stat.req        = req_q;
	assign stat.playing    = playing_q;
	assign stat.can_fetch  = playing_q && ptr_lt_len;
	assign stat.will_sound = sounding_q || start_hit;
	assign stat.div_done   = div_done;

	assign drive_update  = upd_q;
	assign drive_freq_hz = freq_q;
	assign drive_duty    = duty_q;
	assign song_active   = playing_q;
	assign song_finished = end_q;

endmodule

>>> sv/buzzer_melody_sequencer.sv
// Top level of the buzzer melody sequencer.
// An item is taken when start is high and busy is low, and its single result appears on the
// drive and song ports for exactly one cycle while done is high; the receiver cannot hold it
// off. A write, start or ignored item, or a poll while no song plays, passes from decode
// straight to done. A poll during a song goes on through fetch and finish when no note is left
// to check, through fetch, start and finish when the current note is not yet due, and through
// the 31-step serial divider when it reaches a sounding note; the divider runs once for the
// scaled note length and once for the scaled note gap, before the stop check. After done,
// the controller returns to idle, where busy is low, before the next item is taken.
// Configuration writes are always accepted.
module buzzer_melody_sequencer #(
	parameter int MAX_NOTES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bms_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bms_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [1:0]                    req_type,
	input  logic [bms_pkg::SlotW-1:0]     note_slot,
	input  logic [bms_pkg::FreqW-1:0]     note_freq_hz,
	input  logic [bms_pkg::LoudW-1:0]     note_loudness,
	input  logic [bms_pkg::LenW-1:0]      note_length_us,
	input  logic [bms_pkg::ElapW-1:0]     elapsed_us,
	output logic                          drive_update,
	output logic [bms_pkg::FreqW-1:0]     drive_freq_hz,
	output logic [bms_pkg::DutyW-1:0]     drive_duty,
	output logic                          song_active,
	output logic                          song_finished
);
	import bms_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	bms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	bms_dp #(
		.MAX_NOTES (MAX_NOTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.note_slot      (note_slot),
		.note_freq_hz   (note_freq_hz),
		.note_loudness  (note_loudness),
		.note_length_us (note_length_us),
		.elapsed_us     (elapsed_us),
		.cmd            (cmd),
		.stat           (stat),
		.drive_update   (drive_update),
		.drive_freq_hz  (drive_freq_hz),
		.drive_duty     (drive_duty),
		.song_active    (song_active),
		.song_finished  (song_finished)
	);

endmodule

>>> tb/buzzer_melody_sequencer_tb.sv
// Self-checking testbench playing directed and random songs through the sequencer.
module buzzer_melody_sequencer_tb;
	import bms_pkg::*;

	localparam int NoteSlots   = 64;
	localparam int BaseBpm     = 120;
	localparam int GapUs       = 15000;
	localparam int StartLeadUs = 125;

	typedef struct {
		req_t             req;
		logic [SlotW-1:0] slot;
		logic [FreqW-1:0] freq;
		logic [LoudW-1:0] loud;
		logic [LenW-1:0]  len;
		logic [ElapW-1:0] elap;
	} note_req_t;

	typedef struct {
		logic             upd;
		logic [FreqW-1:0] freq;
		logic [DutyW-1:0] duty;
		logic             active;
		logic             finished;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, cfg_ready;
	logic cfg_valid = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic [1:0] req_type = '0;
	logic [SlotW-1:0] note_slot = '0;
	logic [FreqW-1:0] note_freq_hz = '0;
	logic [LoudW-1:0] note_loudness = '0;
	logic [LenW-1:0] note_length_us = '0;
	logic [ElapW-1:0] elapsed_us = '0;
	logic drive_update, song_active, song_finished;
	logic [FreqW-1:0] drive_freq_hz;
	logic [DutyW-1:0] drive_duty;

	note_req_t queued_reqs[$];
	drive_t drive_expected[$];
	logic taken = 1'b0;
	int idle_pct = 0;
	int fails = 0;
	int items_taken = 0;
	int updates = 0;
	int tones = 0;
	int settings_done = 0;

	logic [TempoW-1:0] set_tempo = TempoDefault;
	logic [FreqW-1:0] set_min_freq = '0;
	logic [FreqW-1:0] set_max_freq = '1;
	logic [DutyW-1:0] set_min_duty = '0;
	logic [DutyW-1:0] set_max_duty = '1;
	logic set_repeat = 1'b0;
	logic [PtrW-1:0] set_length = '0;

	logic [FreqW-1:0] tbl_freq [NoteSlots];
	logic [LoudW-1:0] tbl_loud [NoteSlots];
	logic [LenW-1:0] tbl_len [NoteSlots];
	int note_ptr = 0;
	logic [TimeW-1:0] song_clock = '0;
	logic [TimeW-1:0] note_start = '0;
	logic sounding = 1'b0;
	logic at_end = 1'b0;
	logic playing = 1'b0;

	buzzer_melody_sequencer #(.MAX_NOTES(NoteSlots)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_type(req_type),
		.note_slot(note_slot),
		.note_freq_hz(note_freq_hz),
		.note_loudness(note_loudness),
		.note_length_us(note_length_us),
		.elapsed_us(elapsed_us),
		.drive_update(drive_update),
		.drive_freq_hz(drive_freq_hz),
		.drive_duty(drive_duty),
		.song_active(song_active),
		.song_finished(song_finished)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint stretch(longint t);
		longint bpm;
		bpm = (set_tempo == 0) ? BaseBpm : set_tempo;
		return t * BaseBpm / bpm;
	endfunction

	function automatic logic [DutyW-1:0] loud_duty(logic [LoudW-1:0] l);
		int unsigned p;
		p = l * 255;
		if (p >= set_max_duty * 100)
			return set_max_duty;
		if (p <= set_min_duty * 100)
			return set_min_duty;
		return DutyW'(p / 100);
	endfunction

	function automatic void apply_setting(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		case (idx)
			CFG_TEMPO:    set_tempo = data;
			CFG_MIN_FREQ: set_min_freq = data;
			CFG_MAX_FREQ: set_max_freq = data;
			CFG_MIN_DUTY: set_min_duty = data[DutyW-1:0];
			CFG_MAX_DUTY: set_max_duty = data[DutyW-1:0];
			CFG_REPEAT:   set_repeat = data[0];
			CFG_LENGTH:   set_length = data[PtrW-1:0];
			default: ;
		endcase
	endfunction

	function automatic drive_t advance_melody(note_req_t it);
		drive_t r;
		int lim;
		longint c, s0, scl, stop;
		logic [FreqW-1:0] f;
		r = '{default: '0};
		case (it.req)
			REQ_WRITE: begin
				tbl_freq[it.slot] = it.freq;
				tbl_loud[it.slot] = it.loud;
				tbl_len[it.slot] = it.len;
			end
			REQ_START: begin
				r.upd = sounding;
				note_ptr = 0;
				song_clock = '0;
				note_start = '0;
				sounding = 1'b0;
				at_end = 1'b0;
				playing = 1'b1;
			end
			REQ_POLL: begin
				if (playing) begin
					lim = (set_length > NoteSlots) ? NoteSlots : set_length;
					song_clock += it.elap;
					if (at_end) begin
						if (set_repeat) begin
							note_ptr = 0;
							song_clock = '0;
							note_start = '0;
							at_end = 1'b0;
						end else begin
							playing = 1'b0;
						end
					end
					if (playing && note_ptr < lim) begin
						c = song_clock;
						s0 = note_start;
						if (!sounding && c + StartLeadUs >= s0) begin
							f = tbl_freq[note_ptr];
							r.upd = 1'b1;
							if (f >= set_min_freq && f <= set_max_freq) begin
								r.freq = f;
								r.duty = loud_duty(tbl_loud[note_ptr]);
							end
							sounding = 1'b1;
						end
						if (sounding) begin
							scl = stretch(tbl_len[note_ptr]);
							stop = s0 + scl - stretch(GapUs);
							if (c >= stop) begin
								r.upd = 1'b1;
								r.duty = '0;
								sounding = 1'b0;
								note_start += scl[TimeW-1:0];
								note_ptr++;
							end
						end
					end
					if (playing && note_ptr >= lim)
						at_end = 1'b1;
				end
			end
			default: ;
		endcase
		r.active = playing;
		r.finished = at_end;
		return r;
	endfunction

	function automatic note_req_t make_req(req_t rq, logic [31:0] slot, logic [31:0] freq,
			logic [31:0] loud, logic [31:0] len, logic [31:0] elap);
		note_req_t r;
		r.req = rq;
		r.slot = slot[SlotW-1:0];
		r.freq = freq[FreqW-1:0];
		r.loud = loud[LoudW-1:0];
		r.len = len[LenW-1:0];
		r.elap = elap[ElapW-1:0];
		return r;
	endfunction

	// A note whose scaled length stays at most 60 ms whatever the tempo, so songs keep moving.
	function automatic note_req_t tune_note(int slot);
		longint unsigned bpm, cap;
		logic [31:0] f;
		bpm = (set_tempo == 0) ? BaseBpm : set_tempo;
		cap = 60000 * bpm / BaseBpm;
		if (cap > 24'hFFFFFF)
			cap = 24'hFFFFFF;
		if ($urandom_range(0, 7) == 0)
			f = 0;
		else if (set_min_freq <= set_max_freq && $urandom_range(0, 3) != 0)
			f = $urandom_range(set_min_freq, set_max_freq);
		else
			f = $urandom_range(0, 65535);
		return make_req(REQ_WRITE, slot, f, $urandom_range(0, 127), $urandom_range(0, 32'(cap)),
			$urandom);
	endfunction

	always @(negedge clk) begin : driver
		note_req_t nxt;
		if (!start || taken) begin
			if (queued_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nxt = queued_reqs.pop_front();
				start <= 1'b1;
				req_type <= nxt.req;
				note_slot <= nxt.slot;
				note_freq_hz <= nxt.freq;
				note_loudness <= nxt.loud;
				note_length_us <= nxt.len;
				elapsed_us <= nxt.elap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		note_req_t seen_req;
		drive_t want, got;
		taken = arst_n && start && !busy;
		if (taken) begin
			seen_req.req = req_t'(req_type);
			seen_req.slot = note_slot;
			seen_req.freq = note_freq_hz;
			seen_req.loud = note_loudness;
			seen_req.len = note_length_us;
			seen_req.elap = elapsed_us;
			drive_expected.push_back(advance_melody(seen_req));
			items_taken++;
		end
		if (arst_n && done) begin
			got.upd = drive_update;
			got.freq = drive_freq_hz;
			got.duty = drive_duty;
			got.active = song_active;
			got.finished = song_finished;
			if (drive_expected.size() == 0) begin
				$error("drive result arrived with no item awaiting it");
				fails++;
			end else begin
				want = drive_expected.pop_front();
				if (got.upd !== want.upd) begin
					$error("drive_update: expected %0d, got %0d", want.upd, got.upd);
					fails++;
				end
				if (got.freq !== want.freq) begin
					$error("drive_freq_hz: expected %0d, got %0d", want.freq, got.freq);
					fails++;
				end
				if (got.duty !== want.duty) begin
					$error("drive_duty: expected %0d, got %0d", want.duty, got.duty);
					fails++;
				end
				if (got.active !== want.active) begin
					$error("song_active: expected %0d, got %0d", want.active, got.active);
					fails++;
				end
				if (got.finished !== want.finished) begin
					$error("song_finished: expected %0d, got %0d", want.finished, got.finished);
					fails++;
				end
				if (got.upd === 1'b1)
					updates++;
				if (got.freq != 0)
					tones++;
			end
		end
	end

	task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, data);
	endtask

	task automatic set_registers(int tempo, int min_f, int max_f, int min_d, int max_d,
			int rep, int len);
		cfg_write(CFG_TEMPO, CfgDataW'(tempo));
		cfg_write(CFG_MIN_FREQ, CfgDataW'(min_f));
		cfg_write(CFG_MAX_FREQ, CfgDataW'(max_f));
		cfg_write(CFG_MIN_DUTY, CfgDataW'(min_d));
		cfg_write(CFG_MAX_DUTY, CfgDataW'(max_d));
		cfg_write(CFG_REPEAT, CfgDataW'(rep));
		cfg_write(CFG_LENGTH, CfgDataW'(len));
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	task automatic settle();
		logic drained;
		do begin
			@(posedge clk);
			drained = queued_reqs.size() == 0 && !start;
			@(negedge clk);
		end while (!(drained && drive_expected.size() == 0));
		repeat (6) @(posedge clk);
	endtask

	// Songs are written in full first, then restarted and polled, with stray items mixed in.
	task automatic play_random_songs(int n);
		int lim, made, polls, pick;
		lim = (set_length > NoteSlots) ? NoteSlots : set_length;
		made = 0;
		for (int s = 0; s < lim; s++) begin
			queued_reqs.push_back(tune_note(s));
			made++;
		end
		while (made < n) begin
			if (lim != 0) begin
				repeat ($urandom_range(0, 2)) begin
					queued_reqs.push_back(tune_note($urandom_range(0, lim - 1)));
					made++;
				end
			end
			queued_reqs.push_back(make_req(REQ_START, $urandom, $urandom, $urandom, $urandom,
				$urandom));
			made++;
			polls = $urandom_range(4, 10 + 3 * lim);
			repeat (polls) begin
				pick = $urandom_range(0, 79);
				if (pick == 0 && lim < 16)
					queued_reqs.push_back(make_req(REQ_START, $urandom, $urandom, $urandom,
						$urandom, $urandom));
				else if (pick == 1)
					queued_reqs.push_back(make_req(REQ_NONE, $urandom, $urandom, $urandom,
						$urandom, $urandom));
				else if (pick < 4 && lim < NoteSlots)
					queued_reqs.push_back(make_req(REQ_WRITE, $urandom_range(lim, NoteSlots - 1),
						$urandom, $urandom, $urandom, $urandom));
				else if (pick < 4)
					queued_reqs.push_back(tune_note($urandom_range(0, NoteSlots - 1)));
				else
					queued_reqs.push_back(make_req(REQ_POLL, $urandom, $urandom, $urandom,
						$urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
						$urandom_range(0, 20000)));
				made++;
			end
		end
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_registers(TempoDefault, 0, 65535, 0, 255, 0, 3);
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 65535));
		queued_reqs.push_back(make_req(REQ_NONE, '1, '1, '1, '1, '1));
		queued_reqs.push_back(make_req(REQ_WRITE, 0, 65535, 127, 0, 0));
		queued_reqs.push_back(make_req(REQ_WRITE, 1, 0, 100, 40000, 0));
		queued_reqs.push_back(make_req(REQ_WRITE, 2, 440, 50, 30000, 0));
		queued_reqs.push_back(make_req(REQ_WRITE, 63, 1, 0, 24'hFFFFFF, 0));
		queued_reqs.push_back(make_req(REQ_START, 0, 0, 0, 0, 0));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 0));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 0));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 30000));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 5000));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 4875));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 65535));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 1));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 1));
		queued_reqs.push_back(make_req(REQ_START, 0, 0, 0, 0, 0));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 0));
		queued_reqs.push_back(make_req(REQ_POLL, 0, 0, 0, 0, 0));
		queued_reqs.push_back(make_req(REQ_START, 0, 0, 0, 0, 0));
		queued_reqs.push_back(make_req(REQ_WRITE, 42, 16'h5555, 7'h2A, 24'hAAAAAA, 0));

		settle();
		set_registers(120, 0, 65535, 0, 255, 0, 5);
		idle_pct = 0;
		play_random_songs(300);

		settle();
		set_registers(65535, 300, 4000, 40, 180, 1, 8);
		idle_pct = 46;
		play_random_songs(300);

		settle();
		set_registers(0, 1000, 1000, 255, 0, 1, 127);
		idle_pct = 0;
		play_random_songs(350);

		settle();
		set_registers(1, 65535, 0, 100, 100, 0, 3);
		idle_pct = 24;
		play_random_songs(250);

		settle();
		set_registers(90, 0, 65535, 0, 128, 1, 1);
		idle_pct = 46;
		play_random_songs(250);

		settle();
		set_registers(240, 50, 60000, 10, 250, 0, 0);
		idle_pct = 0;
		play_random_songs(100);

		settle();
		set_registers(150, 20, 20000, 0, 255, 1, 64);
		idle_pct = 24;
		play_random_songs(300);

		settle();
		$display("Played %0d items under %0d register settings, directed songs then random ones.",
			items_taken, settings_done);
		$display("Checked %0d drive updates, %0d of which sounded a tone.", updates, tones);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
